@@ rtl/rwp_pkg.sv @@
// Shared widths, command codes and the cell control bundle for the
// rolling window percentile block. No dependencies.
package rwp_pkg;

  localparam int unsigned VAL_W     = 64;
  localparam int unsigned TENTHS_W  = 10;
  localparam int unsigned COUNT_W   = 11;
  localparam int unsigned RWP_DEPTH = 1024;
  localparam int unsigned PCT_SCALE = 1000;
  localparam int unsigned SCALE_W   = $clog2(PCT_SCALE);

  localparam logic CMD_RECORD = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  typedef struct packed {
    logic upd;
    logic full;
    logic left;
  } rwp_cell_ctrl_t;

endpackage

@@ rtl/rolling_window_percentile_core.sv @@
// Top level: ring store, sorted cell chain, rank pipeline and grouped readout.
// Depends on rwp_pkg, rwp_cell and rwp_rank.
//
//  channel | direction | ports
//  --------+-----------+---------------------------------------------------------
//  in      | sink      | in_valid, in_stall, in_command, in_sample_value,
//          |           | in_percentile_tenths
//  out     | source    | out_valid, out_stall, out_percentile_value,
//          |           | out_window_empty, out_sample_count
//
// A record beat is a ring read of the oldest sample, then one shift of the
// cell chain (delete oldest, insert new) with the ring write.
// A query beat passes 3 rank pipeline stages (product on accept, multiply,
// clamped rank), the group readout register, then the output register load;
// the load waits while the result register holds an earlier beat under out_stall.
// Synchronous active-low reset clears the chain valid bits, count, slot, state and output valid.
// in_stall is high whenever an item is in progress.
module rolling_window_percentile_core #(
  parameter int unsigned WINDOW_DEPTH = rwp_pkg::RWP_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_command,
  input  logic [rwp_pkg::VAL_W-1:0]     in_sample_value,
  input  logic [rwp_pkg::TENTHS_W-1:0]  in_percentile_tenths,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rwp_pkg::VAL_W-1:0]     out_percentile_value,
  output logic                          out_window_empty,
  output logic [rwp_pkg::COUNT_W-1:0]   out_sample_count
);
  import rwp_pkg::*;

  localparam int unsigned N     = WINDOW_DEPTH;
  localparam int unsigned CNT_W = $clog2(N + 1);
  localparam int unsigned IDX_W = $clog2(N);
  localparam int unsigned GRP_W = (IDX_W < 5) ? IDX_W : 5;
  localparam int unsigned GS    = 1 << GRP_W;
  localparam int unsigned NG    = (N + GS - 1) / GS;
  localparam int unsigned PAD   = NG * GS;
  localparam int unsigned HI_W  = (NG > 1) ? $clog2(NG) : 1;

  typedef enum logic [1:0] {S_IDLE, S_REC, S_RANK, S_GRP} state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [IDX_W-1:0]   wslot_r, wslot_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0]   out_val_r, out_val_nxt;
  logic               out_empty_r, out_empty_nxt;
  logic [COUNT_W-1:0] out_cnt_r, out_cnt_nxt;

  logic [VAL_W-1:0]   new_val_r;
  logic [VAL_W-1:0]   rd_r;
  logic [VAL_W-1:0]   mem [N];

  logic               acc_in;
  logic               rank_go;
  logic               rank_done;
  logic [IDX_W-1:0]   rank;
  logic [GRP_W-1:0]   lo;
  logic [HI_W-1:0]    hi;
  rwp_cell_ctrl_t     ctrl;

  logic [VAL_W-1:0]   cell_val [N];
  logic               cell_vld [N];
  logic               cell_p   [N];
  logic               cell_d   [N];
  logic [VAL_W-1:0]   cell_pad [PAD];
  logic [VAL_W-1:0]   grp_val  [NG];

  assign acc_in  = in_valid && !in_stall;
  assign rank_go = acc_in && (in_command == CMD_QUERY);
  assign in_stall = (state_r != S_IDLE);

  assign ctrl.upd  = (state_r == S_REC);
  assign ctrl.full = (cnt_r == CNT_W'(N));
  assign ctrl.left = ctrl.full && (rd_r <= new_val_r);

  assign out_valid            = out_valid_r;
  assign out_percentile_value = out_val_r;
  assign out_window_empty     = out_empty_r;
  assign out_sample_count     = out_cnt_r;

  // ring store of samples in arrival order
  always_ff @(posedge clk) begin
    if (state_r == S_REC) begin
      mem[wslot_r] <= new_val_r;
    end
    rd_r <= mem[wslot_r];
  end

  always_ff @(posedge clk) begin
    if (acc_in) begin
      new_val_r <= in_sample_value;
    end
  end

  rwp_rank #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) u_rank (
    .clk    (clk),
    .rst_n  (rst_n),
    .go     (rank_go),
    .tenths (in_percentile_tenths),
    .count  (cnt_r),
    .rank   (rank),
    .done   (rank_done)
  );

  genvar gi;
  generate
    for (gi = 0; gi < N; gi++) begin : g_cell
      logic [VAL_W-1:0] pv, nv;
      logic             pvl, pp, pd, nvl, np;
      if (gi == 0) begin : g_first
        assign pv  = '0;
        assign pvl = 1'b0;
        assign pp  = 1'b0;
        assign pd  = 1'b0;
      end else begin : g_mid
        assign pv  = cell_val[gi-1];
        assign pvl = cell_vld[gi-1];
        assign pp  = cell_p[gi-1];
        assign pd  = cell_d[gi-1];
      end
      if (gi == N - 1) begin : g_last
        assign nv  = '0;
        assign nvl = 1'b0;
        assign np  = 1'b1;
      end else begin : g_inner
        assign nv  = cell_val[gi+1];
        assign nvl = cell_vld[gi+1];
        assign np  = cell_p[gi+1];
      end
      rwp_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .new_val  (new_val_r),
        .old_val  (rd_r),
        .prev_val (pv),
        .prev_vld (pvl),
        .prev_p   (pp),
        .prev_d   (pd),
        .next_val (nv),
        .next_vld (nvl),
        .next_p   (np),
        .val      (cell_val[gi]),
        .vld      (cell_vld[gi]),
        .p        (cell_p[gi]),
        .d        (cell_d[gi])
      );
    end

    for (gi = 0; gi < PAD; gi++) begin : g_pad
      if (gi < N) begin : g_real
        assign cell_pad[gi] = cell_val[gi];
      end else begin : g_zero
        assign cell_pad[gi] = '0;
      end
    end

    for (gi = 0; gi < NG; gi++) begin : g_grp
      logic [VAL_W-1:0] seg [GS];
      logic [VAL_W-1:0] grp_r;
      for (genvar k = 0; k < GS; k++) begin : g_seg
        assign seg[k] = cell_pad[gi*GS + k];
      end
      always_ff @(posedge clk) begin
        grp_r <= seg[lo];
      end
      assign grp_val[gi] = grp_r;
    end
  endgenerate

  assign lo = rank[GRP_W-1:0];
  assign hi = HI_W'(rank >> GRP_W);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    wslot_nxt     = wslot_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_val_nxt   = out_val_r;
    out_empty_nxt = out_empty_r;
    out_cnt_nxt   = out_cnt_r;
    case (state_r)
      S_IDLE: begin
        if (acc_in) begin
          state_nxt = (in_command == CMD_QUERY) ? S_RANK : S_REC;
        end
      end
      S_REC: begin
        state_nxt = S_IDLE;
        wslot_nxt = (wslot_r == IDX_W'(N - 1)) ? '0 : wslot_r + 1'b1;
        if (!ctrl.full) begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_RANK: begin
        if (rank_done) begin
          state_nxt = S_GRP;
        end
      end
      S_GRP: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = (cnt_r == '0) ? '0 : grp_val[hi];
          out_empty_nxt = (cnt_r == '0);
          out_cnt_nxt   = COUNT_W'(cnt_r);
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      wslot_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      wslot_r     <= wslot_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_val_r   <= out_val_nxt;
    out_empty_r <= out_empty_nxt;
    out_cnt_r   <= out_cnt_nxt;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(N))
    else $error("fill count above depth");

  a_slot_tracks_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != CNT_W'(N)) |-> (wslot_r == IDX_W'(cnt_r)))
    else $error("write slot out of step with fill count");

  a_out_from_grp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_GRP))
    else $error("result loaded outside readout");

  a_rank_in_query: assert property (@(posedge clk) disable iff (!rst_n)
    rank_done |-> (state_r == S_RANK))
    else $error("rank done outside query");

endmodule

@@ rtl/rwp_cell.sv @@
// One cell of the sorted sample chain: holds one sample and its valid bit.
// Depends on rwp_pkg.
module rwp_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  rwp_pkg::rwp_cell_ctrl_t      ctrl,
  input  logic [rwp_pkg::VAL_W-1:0]    new_val,
  input  logic [rwp_pkg::VAL_W-1:0]    old_val,
  input  logic [rwp_pkg::VAL_W-1:0]    prev_val,
  input  logic                         prev_vld,
  input  logic                         prev_p,
  input  logic                         prev_d,
  input  logic [rwp_pkg::VAL_W-1:0]    next_val,
  input  logic                         next_vld,
  input  logic                         next_p,
  output logic [rwp_pkg::VAL_W-1:0]    val,
  output logic                         vld,
  output logic                         p,
  output logic                         d
);
  import rwp_pkg::*;

  logic [VAL_W-1:0] val_r, val_nxt;
  logic             vld_r, vld_nxt;

  assign p   = !vld_r || (val_r > new_val);
  assign d   = ctrl.full && vld_r && (val_r >= old_val);
  assign val = val_r;
  assign vld = vld_r;

  always_comb begin
    val_nxt = val_r;
    vld_nxt = vld_r;
    if (ctrl.upd) begin
      if (ctrl.left) begin
        if (d && !p) begin
          if (next_p) begin
            val_nxt = new_val;
            vld_nxt = 1'b1;
          end else begin
            val_nxt = next_val;
            vld_nxt = next_vld;
          end
        end
      end else if (p && !prev_d) begin
        if (prev_p) begin
          val_nxt = prev_val;
          vld_nxt = prev_vld;
        end else begin
          val_nxt = new_val;
          vld_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

endmodule

@@ rtl/rwp_rank.sv @@
// Three-stage rank pipeline: floor(tenths * count / 1000) by reciprocal
// multiply, clamped to count - 1. Depends on rwp_pkg.
module rwp_rank #(
  parameter int unsigned WINDOW_DEPTH = rwp_pkg::RWP_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                go,
  input  logic [rwp_pkg::TENTHS_W-1:0]        tenths,
  input  logic [$clog2(WINDOW_DEPTH+1)-1:0]   count,
  output logic [$clog2(WINDOW_DEPTH)-1:0]     rank,
  output logic                                done
);
  import rwp_pkg::*;

  localparam int unsigned CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned IDX_W = $clog2(WINDOW_DEPTH);
  localparam int unsigned PW    = TENTHS_W + CNT_W;
  localparam int unsigned SH    = PW + SCALE_W;
  localparam int unsigned MW    = PW + 1;
  localparam logic [63:0] RECIP = ((64'd1 << SH) + 64'(PCT_SCALE) - 64'd1) / 64'(PCT_SCALE);

  logic [PW-1:0]    prod_r;
  logic [PW+MW-1:0] mul_r;
  logic [IDX_W-1:0] rank_r;
  logic [CNT_W:0]   quo;
  logic             v1_r, v2_r, v3_r;

  assign quo  = mul_r[SH +: CNT_W+1];
  assign rank = rank_r;
  assign done = v3_r;

  // hold the product until the next query so rank stays put through readout
  always_ff @(posedge clk) begin
    if (go) begin
      prod_r <= PW'(tenths) * PW'(count);
    end
    mul_r  <= (PW+MW)'(prod_r) * (PW+MW)'(RECIP[MW-1:0]);
    rank_r <= (quo >= (CNT_W+1)'(count)) ? IDX_W'(count - 1'b1) : IDX_W'(quo);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= go;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

endmodule
